### rtl/assert_macros.svh
// Assertion macros used by the allocator datapath.
// Each check is clocked on aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define BBA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication check
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Sizes, status codes, controller/datapath interface types and tree indexing.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MIN_ORDER   = 7;
    localparam int MAX_ORDER   = 17;
    localparam int NUM_ORD     = MAX_ORDER - MIN_ORDER + 1;
    localparam int MAP_DEPTH   = 1 << NUM_ORD;
    localparam int NODE_W      = NUM_ORD;
    localparam int LVL_W       = $clog2(NUM_ORD);
    localparam int CNT_W       = NUM_ORD;
    localparam int OFF_W       = 17;
    localparam int REQ_W       = 17;
    localparam int ORD_W       = 5;
    localparam int OVH_W       = 8;
    localparam int TOT_W       = REQ_W + 1;
    localparam int FIT_W       = (TOT_W > MAX_ORDER + 1) ? TOT_W : MAX_ORDER + 1;
    localparam int DEFAULT_OVH = 32;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 24;

    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_FREED   = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_BAD     = 2'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_in;
        logic    alloc_ord;
        logic    pick;
        logic    scan;
        logic    take;
        logic    split_rd;
        logic    split_wr;
        logic    self_rd;
        logic    self_wr;
        logic    bud_rd;
        logic    bud_merge;
        logic    clr;
        logic    res_load;
        status_t res_status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode;
        logic oversize;
        logic no_space;
        logic free_bad;
        logic rd_one;
        logic rd_hit;
        logic can_split;
        logic at_top;
        logic clr_last;
        logic out_free;
    } sts_t;

    // Tree node of the block at offset off and order ord
    function automatic logic [NODE_W-1:0] node_of(input logic [OFF_W-1:0] off,
                                                  input logic [ORD_W-1:0] ord);
        logic [OFF_W-1:0]  sh;
        logic [NODE_W-1:0] top;
        sh  = off >> ord;
        top = NODE_W'(1) << (ORD_W'(MAX_ORDER) - ord);
        return top + sh[NODE_W-1:0];
    endfunction

endpackage

### rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/bba_datapath.sv
// ----------------------------------------------------------------------------
// Buddy allocator datapath
// Free map RAM, per-order free counters, working registers and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_mode,
    input  logic [bba_pkg::REQ_W-1:0]       in_req,
    input  logic [bba_pkg::OFF_W-1:0]       in_off,
    input  logic [bba_pkg::ORD_W-1:0]       in_ord,
    input  logic                            cfg_valid,
    input  logic [bba_pkg::OVH_W-1:0]       cfg_data,
    input  bba_pkg::cmd_t                   cmd,
    output bba_pkg::sts_t                   sts,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output bba_pkg::status_t                res_status,
    output logic [bba_pkg::OFF_W-1:0]       res_off,
    output logic [bba_pkg::ORD_W-1:0]       res_ord
);
    import bba_pkg::*;

    logic [OVH_W-1:0]  ovh_reg;
    logic              mode_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [ORD_W-1:0]  ord_reg;
    logic [ORD_W-1:0]  tgt_reg;
    logic [NODE_W-1:0] scan_reg;
    logic [NODE_W-1:0] hit_reg;
    logic [NODE_W-1:0] clr_reg;
    logic              pend_reg;
    logic [CNT_W-1:0]  cnt_reg [NUM_ORD];
    logic              m_tvalid_reg;
    status_t           status_reg;
    logic [OFF_W-1:0]  res_off_reg;
    logic [ORD_W-1:0]  res_ord_reg;

    logic [TOT_W-1:0]   total;
    logic [ORD_W-1:0]   alloc_ord;
    logic               oversize;
    logic [LVL_W-1:0]   lvl_tgt;
    logic [LVL_W-1:0]   lvl_cur;
    logic [LVL_W-1:0]   lvl_dn;
    logic [ORD_W-1:0]   srch_ord;
    logic               no_space;
    logic [NUM_ORD-1:0] cnt_nz;
    logic [OFF_W-1:0]   align_mask;
    logic               free_bad;
    logic [OFF_W-1:0]   bit_cur;
    logic [OFF_W-1:0]   bit_dn;
    logic [NODE_W-1:0]  node_self;
    logic [NODE_W-1:0]  node_bud;
    logic [NODE_W-1:0]  node_up;
    logic [NODE_W-1:0]  lvl_base;
    logic [NODE_W-1:0]  srch_base;
    logic [OFF_W-1:0]   hit_off;
    logic [NODE_W-1:0]  ram_addr;
    logic               ram_we;
    logic [0:0]         ram_wdata;
    logic [0:0]         ram_rdata;
    logic               out_free;

    // Rounded allocation order: smallest order whose block holds the total
    assign total = TOT_W'(req_reg) + TOT_W'(ovh_reg);
    always_comb begin
        oversize  = 1'b1;
        alloc_ord = ORD_W'(MIN_ORDER);
        for (int i = NUM_ORD - 1; i >= 0; i--) begin
            if (FIT_W'(total) <= (FIT_W'(1) << (MIN_ORDER + i))) begin
                oversize  = 1'b0;
                alloc_ord = ORD_W'(MIN_ORDER + i);
            end
        end
    end

    // Smallest sufficient order that still has a free block
    assign lvl_tgt = LVL_W'(tgt_reg - ORD_W'(MIN_ORDER));
    always_comb begin
        no_space = 1'b1;
        srch_ord = ORD_W'(MIN_ORDER);
        for (int i = NUM_ORD - 1; i >= 0; i--) begin
            cnt_nz[i] = (cnt_reg[i] != '0);
            if ((LVL_W'(i) >= lvl_tgt) && cnt_nz[i]) begin
                no_space = 1'b0;
                srch_ord = ORD_W'(MIN_ORDER + i);
            end
        end
    end

    // Free request checks: order range, pool range, alignment
    assign align_mask = ~({OFF_W{1'b1}} << ord_reg);
    assign free_bad   = (ord_reg < ORD_W'(MIN_ORDER)) || (ord_reg > ORD_W'(MAX_ORDER)) ||
                        (({1'b0, off_reg} >> MAX_ORDER) != '0) ||
                        ((off_reg & align_mask) != '0);

    // Node addresses around the current block
    assign lvl_cur   = LVL_W'(ord_reg - ORD_W'(MIN_ORDER));
    assign lvl_dn    = lvl_cur - LVL_W'(1);
    assign bit_cur   = OFF_W'(1) << ord_reg;
    assign bit_dn    = OFF_W'(1) << (ord_reg - ORD_W'(1));
    assign node_self = node_of(off_reg, ord_reg);
    assign node_bud  = node_of(off_reg ^ bit_cur, ord_reg);
    assign node_up   = node_of(off_reg | bit_dn, ord_reg - ORD_W'(1));
    assign lvl_base  = NODE_W'(1) << (ORD_W'(MAX_ORDER) - ord_reg);
    assign srch_base = NODE_W'(1) << (ORD_W'(MAX_ORDER) - srch_ord);
    assign hit_off   = OFF_W'(hit_reg & (lvl_base - NODE_W'(1))) << ord_reg;

    // Free map port
    always_comb begin
        priority if (cmd.clr) begin
            ram_addr = clr_reg;
        end else if (cmd.scan) begin
            ram_addr = scan_reg;
        end else if (cmd.take) begin
            ram_addr = hit_reg;
        end else if (cmd.split_rd || cmd.split_wr) begin
            ram_addr = node_up;
        end else if (cmd.bud_rd || cmd.bud_merge) begin
            ram_addr = node_bud;
        end else begin
            ram_addr = node_self;
        end
    end
    assign ram_we    = cmd.clr || cmd.take || cmd.split_wr || cmd.bud_merge || cmd.self_wr;
    assign ram_wdata = cmd.clr ? 1'(clr_reg == NODE_W'(1))
                     : ((cmd.take || cmd.bud_merge) ? 1'b0 : 1'b1);

    bba_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_free_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovh_reg <= OVH_W'(DEFAULT_OVH);
        end else if (cfg_valid) begin
            ovh_reg <= cfg_data;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mode_reg <= in_mode;
            req_reg  <= in_req;
            off_reg  <= in_off;
            ord_reg  <= in_ord;
        end
        if (cmd.alloc_ord) begin
            tgt_reg <= alloc_ord;
        end
        if (cmd.pick) begin
            ord_reg  <= srch_ord;
            scan_reg <= srch_base;
        end
        if (cmd.scan) begin
            scan_reg <= scan_reg + NODE_W'(1);
            hit_reg  <= scan_reg;
        end
        if (cmd.take) begin
            off_reg <= hit_off;
        end
        if (cmd.split_wr) begin
            ord_reg <= ord_reg - ORD_W'(1);
        end
        if (cmd.bud_merge) begin
            off_reg <= off_reg & ~bit_cur;
            ord_reg <= ord_reg + ORD_W'(1);
        end
    end

    // Scan read tracking and clearing pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            clr_reg  <= '0;
        end else begin
            pend_reg <= cmd.scan;
            if (cmd.clr) begin
                clr_reg <= clr_reg + NODE_W'(1);
            end
        end
    end

    // Free block count per order, mirrors the map bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ORD; i++) begin
                cnt_reg[i] <= (i == NUM_ORD - 1) ? CNT_W'(1) : '0;
            end
        end else begin
            for (int i = 0; i < NUM_ORD; i++) begin
                if ((cmd.take || cmd.bud_merge) && (lvl_cur == LVL_W'(i))) begin
                    cnt_reg[i] <= cnt_reg[i] - CNT_W'(1);
                end else if ((cmd.split_wr && !ram_rdata[0] && (lvl_dn == LVL_W'(i))) ||
                             (cmd.self_wr && !ram_rdata[0] && (lvl_cur == LVL_W'(i)))) begin
                    cnt_reg[i] <= cnt_reg[i] + CNT_W'(1);
                end
            end
        end
    end

    // Result register
    assign out_free = !m_tvalid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            status_reg <= cmd.res_status;
            if (cmd.res_status == ST_ALLOC || cmd.res_status == ST_FREED) begin
                res_off_reg <= off_reg;
                res_ord_reg <= ord_reg;
            end else begin
                res_off_reg <= '0;
                res_ord_reg <= '0;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign res_status = status_reg;
    assign res_off    = res_off_reg;
    assign res_ord    = res_ord_reg;

    assign sts.mode      = mode_reg;
    assign sts.oversize  = oversize;
    assign sts.no_space  = no_space;
    assign sts.free_bad  = free_bad;
    assign sts.rd_one    = ram_rdata[0];
    assign sts.rd_hit    = pend_reg && ram_rdata[0];
    assign sts.can_split = ord_reg > tgt_reg;
    assign sts.at_top    = ord_reg == ORD_W'(MAX_ORDER);
    assign sts.clr_last  = clr_reg == NODE_W'(MAP_DEPTH - 1);
    assign sts.out_free  = out_free;

    // At most one map write per cycle
    `BBA_ASSERT(a_one_write, $onehot0({cmd.clr, cmd.take, cmd.split_wr, cmd.bud_merge, cmd.self_wr}), "two map writes in one cycle")
    // A taken or merged block must be counted
    `BBA_ASSERT_IMPL(a_cnt_live, cmd.take || cmd.bud_merge, cnt_nz[lvl_cur], "free count underflow")
    // A result never overwrites one still waiting
    `BBA_ASSERT_IMPL(a_res_room, cmd.res_load, out_free, "result register overrun")

endmodule

### rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Buddy allocator controller
// Sequences the clearing pass, search, split, coalesce and result handoff.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_PICK, S_SCAN, S_TAKE, S_SPLIT_RD, S_SPLIT_WR,
        S_FCHK_RD, S_FCHK, S_FLOOP, S_FBUD, S_FSET_RD, S_FSET_WR, S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;

    assign s_tready = (state_reg == S_IDLE);

    // Command decode and next state
    always_comb begin
        cmd            = '0;
        cmd.res_status = res_reg;
        state_next     = state_reg;
        res_next       = res_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!sts.mode) begin
                    if (sts.oversize) begin
                        res_next   = ST_BAD;
                        state_next = S_RESULT;
                    end else begin
                        cmd.alloc_ord = 1'b1;
                        state_next    = S_PICK;
                    end
                end else if (sts.free_bad) begin
                    res_next   = ST_BAD;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_FCHK_RD;
                end
            end
            S_PICK: begin
                if (sts.no_space) begin
                    res_next   = ST_NOSPACE;
                    state_next = S_RESULT;
                end else begin
                    cmd.pick   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.rd_hit) begin
                    state_next = S_TAKE;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            S_TAKE: begin
                cmd.take   = 1'b1;
                state_next = S_SPLIT_RD;
            end
            S_SPLIT_RD: begin
                if (sts.can_split) begin
                    cmd.split_rd = 1'b1;
                    state_next   = S_SPLIT_WR;
                end else begin
                    res_next   = ST_ALLOC;
                    state_next = S_RESULT;
                end
            end
            S_SPLIT_WR: begin
                cmd.split_wr = 1'b1;
                state_next   = S_SPLIT_RD;
            end
            S_FCHK_RD: begin
                cmd.self_rd = 1'b1;
                state_next  = S_FCHK;
            end
            S_FCHK: begin
                // double free
                if (sts.rd_one) begin
                    res_next   = ST_BAD;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_FLOOP;
                end
            end
            S_FLOOP: begin
                if (sts.at_top) begin
                    state_next = S_FSET_RD;
                end else begin
                    cmd.bud_rd = 1'b1;
                    state_next = S_FBUD;
                end
            end
            S_FBUD: begin
                if (sts.rd_one) begin
                    cmd.bud_merge = 1'b1;
                    state_next    = S_FLOOP;
                end else begin
                    state_next = S_FSET_RD;
                end
            end
            S_FSET_RD: begin
                cmd.self_rd = 1'b1;
                state_next  = S_FSET_WR;
            end
            S_FSET_WR: begin
                cmd.self_wr = 1'b1;
                res_next    = ST_FREED;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            res_reg   <= ST_BAD;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

### rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a 2^17 byte pool.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 2048-entry free map,
// one entry a cycle, and takes no request until the pass is done (overhead
// writes are taken at any time). Each request then yields one result. The
// free map is a single-port RAM touched once per cycle, which sets the timing.
// An allocate scans the map entries of the chosen order (up to 2^(17-order),
// lowest free block first), then splits the block down to the needed order.
// A free merges with its buddy while the buddy is free, up to the top order,
// then marks the merged block free. The next request is taken in the cycle
// after the result is loaded. A finished result waits in the output register
// while the next request is taken. The result load waits while that register
// is still full.
module buddy_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,      // mode
    input  logic [39:0] s_tdata,      // request_bytes, block_offset, free_order, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,      // status
    output logic [23:0] m_tdata,      // block_offset_out, block_order_out, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data      // overhead_bytes
);
    import bba_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    status_t          res_status;
    logic [OFF_W-1:0] res_off;
    logic [ORD_W-1:0] res_ord;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_mode    (s_tuser),
        .in_req     (s_tdata[16:0]),
        .in_off     (s_tdata[33:17]),
        .in_ord     (s_tdata[38:34]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .res_status (res_status),
        .res_off    (res_off),
        .res_ord    (res_ord)
    );

    // Result packing
    assign m_tuser = res_status;
    assign m_tdata = {2'b00, res_ord, res_off};

endmodule
